@@ rtl/lmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared constants and control types of the LED matrix line loader and row
// scanner.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  localparam int ROWS_DEFAULT          = 8;
  localparam int BYTES_PER_ROW_DEFAULT = 24;

  localparam int BYTE_W  = 8;
  localparam int ANODE_W = 3;

  // input commands
  localparam logic CMD_SERIAL = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // characters the line parser looks for
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_LOW_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOW_F  = 8'h66;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_byte;   // serial character accepted, run the parser
    logic take_tick;   // row tick accepted, advance lit row
    logic commit_wr;   // write one byte of the committed line
    logic scan_rd;     // issue one frame store read for the scan
  } lmrs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic line_done;   // the character on the input completes a line
    logic k_last;      // byte counter sits on the final byte of a row
    logic issue_ok;    // read pipeline has room for another byte
  } lmrs_stat_t;

endpackage

@@ rtl/lmrs_in_if.sv @@
// ----------------------------------------------------------------------------
// lmrs_in_if
// Input channel: serial characters and row ticks.
// ----------------------------------------------------------------------------
interface lmrs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [lmrs_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

@@ rtl/lmrs_out_if.sv @@
// ----------------------------------------------------------------------------
// lmrs_out_if
// Output channel: one byte for the column drivers per transfer.
// ----------------------------------------------------------------------------
interface lmrs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lmrs_pkg::ANODE_W-1:0] anode_row;
  logic                        latch_pulse;
  logic [lmrs_pkg::BYTE_W-1:0]  shift_byte;
  logic                        last;

  modport source (output valid, output anode_row, output latch_pulse,
                  output shift_byte, output last, input ready);
  modport sink (input valid, input anode_row, input latch_pulse,
                input shift_byte, input last, output ready);
endinterface

@@ rtl/lmrs_ram.sv @@
// ----------------------------------------------------------------------------
// lmrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/lmrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lmrs_ctrl
// Sequencer: accepts items, then runs the line commit or the row scan sweep.
// ----------------------------------------------------------------------------
module lmrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  lmrs_pkg::lmrs_stat_t stat,
  output lmrs_pkg::lmrs_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_SCAN
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take_byte = in_valid && (in_command == lmrs_pkg::CMD_SERIAL);
        cmd.take_tick = in_valid && (in_command == lmrs_pkg::CMD_TICK);
      end
      ST_COMMIT: begin
        cmd.commit_wr = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_rd = stat.issue_ok;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.take_tick) begin
            state <= ST_SCAN;
          end else if (cmd.take_byte && stat.line_done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (stat.k_last) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (stat.issue_ok && stat.k_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/lmrs_datapath.sv @@
// ----------------------------------------------------------------------------
// lmrs_datapath
// Line parser, line buffer, frame store with row valid bits, scan pipeline
// and output register.
// ----------------------------------------------------------------------------
module lmrs_datapath #(
  parameter int ROWS          = lmrs_pkg::ROWS_DEFAULT,
  parameter int BYTES_PER_ROW = lmrs_pkg::BYTES_PER_ROW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lmrs_pkg::lmrs_cmd_t           cmd,
  output lmrs_pkg::lmrs_stat_t          stat,
  input  logic [lmrs_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lmrs_pkg::ANODE_W-1:0]  anode_row,
  output logic                          latch_pulse,
  output logic [lmrs_pkg::BYTE_W-1:0]   shift_byte,
  output logic                          last
);

  localparam int HALF_ROW = BYTES_PER_ROW / 2;
  localparam int LOW_ZERO = BYTES_PER_ROW - HALF_ROW;
  localparam int DIGITS   = 2 * HALF_ROW;
  localparam int DEPTH    = ROWS * BYTES_PER_ROW;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int K_W      = $clog2(BYTES_PER_ROW);
  localparam int DC_W     = $clog2(DIGITS);
  localparam int IDX_W    = (HALF_ROW > 1) ? $clog2(HALF_ROW) : 1;
  localparam int BW       = lmrs_pkg::BYTE_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LINE,
    PH_DATA
  } phase_t;

  phase_t          phase;
  logic [DC_W-1:0] digit_count;
  logic [ROW_W-1:0] target_row;
  logic [BW-1:0]   line_buf [HALF_ROW];
  logic [ROW_W-1:0] lit_row;
  logic [ROW_W-1:0] scan_row;
  logic            latch_pending;
  logic            scan_latch;
  logic [ROWS-1:0] row_valid;
  logic [K_W-1:0]  k;

  // read pipeline stage sitting on the ram read register
  logic             s1_valid;
  logic             s1_latch;
  logic             s1_last;
  logic             s1_zero;
  logic [ROW_W-1:0] s1_anode;

  logic             is_dollar;
  logic             is_row_digit;
  logic             is_hex;
  logic [3:0]       nibble;
  logic [BW-1:0]    rx_off;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [K_W-1:0]   k_off;
  logic [ROW_W-1:0] lit_next;
  logic [ROW_W-1:0] ram_row;
  logic [ADDR_W-1:0] ram_addr;
  logic [BW-1:0]    commit_data;
  logic [BW-1:0]    ram_rd_data;
  logic             out_free;

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    row_inc = (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

  // character classes
  always_comb begin
    is_dollar    = (rx_byte == lmrs_pkg::CHAR_DOLLAR);
    is_row_digit = (rx_byte >= lmrs_pkg::CHAR_ZERO) &&
                   (rx_byte < lmrs_pkg::CHAR_ZERO + BW'(ROWS));
    rx_off       = rx_byte - lmrs_pkg::CHAR_ZERO;
    is_hex       = 1'b0;
    nibble       = '0;
    if ((rx_byte >= lmrs_pkg::CHAR_ZERO) && (rx_byte <= lmrs_pkg::CHAR_NINE)) begin
      is_hex = 1'b1;
      nibble = rx_off[3:0];
    end else if ((rx_byte >= lmrs_pkg::CHAR_LOW_A) && (rx_byte <= lmrs_pkg::CHAR_LOW_F)) begin
      is_hex = 1'b1;
      nibble = 4'(rx_byte - lmrs_pkg::CHAR_LOW_A + BW'(10));
    end
  end

  assign wr_idx = IDX_W'(digit_count >> 1);
  assign k_off  = k - K_W'(LOW_ZERO);
  assign rd_idx = IDX_W'(k_off);

  assign stat.line_done = (phase == PH_DATA) && !is_dollar && is_hex &&
                          (digit_count == DC_W'(DIGITS - 1));
  assign stat.k_last    = (k == K_W'(BYTES_PER_ROW - 1));

  assign out_free      = !out_valid || out_ready;
  assign stat.issue_ok = !s1_valid || out_free;

  // low half of a committed row is zero, upper half from the line buffer
  assign commit_data = (k < K_W'(LOW_ZERO)) ? '0 : line_buf[rd_idx];

  assign lit_next = row_inc(lit_row);
  assign ram_row  = cmd.commit_wr ? target_row : scan_row;
  assign ram_addr = ADDR_W'(ram_row) * ADDR_W'(BYTES_PER_ROW) + ADDR_W'(k);

  lmrs_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (cmd.commit_wr),
    .wr_addr (ram_addr),
    .wr_data (commit_data),
    .rd_en   (cmd.scan_rd),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  // parser, control registers and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      digit_count   <= '0;
      target_row    <= '0;
      lit_row       <= '0;
      latch_pending <= 1'b0;
      row_valid     <= '0;
      k             <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.take_byte) begin
        if (is_dollar) begin
          digit_count <= '0;
          phase       <= PH_LINE;
        end else begin
          unique case (phase)
            PH_LINE: begin
              if (is_row_digit) begin
                target_row <= ROW_W'(rx_off);
                phase      <= PH_DATA;
              end else begin
                phase <= PH_IDLE;
              end
            end
            PH_DATA: begin
              if (!is_hex) begin
                phase <= PH_IDLE;
              end else if (stat.line_done) begin
                digit_count <= '0;
                phase       <= PH_IDLE;
              end else begin
                digit_count <= digit_count + 1'b1;
              end
            end
            default: begin
              phase <= PH_IDLE;
            end
          endcase
        end
      end

      if (cmd.take_byte || cmd.take_tick) begin
        k <= '0;
      end else if (cmd.commit_wr || cmd.scan_rd) begin
        k <= stat.k_last ? '0 : k + 1'b1;
      end

      if (cmd.take_tick) begin
        lit_row       <= lit_next;
        latch_pending <= 1'b1;
      end

      if (cmd.commit_wr) begin
        row_valid[target_row] <= 1'b1;
      end

      if (cmd.scan_rd) begin
        s1_valid <= 1'b1;
      end else if (s1_valid && out_free) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_byte && !is_dollar && (phase == PH_DATA) && is_hex) begin
      if (!digit_count[0]) begin
        line_buf[wr_idx] <= {nibble, 4'b0000};
      end else begin
        line_buf[wr_idx] <= line_buf[wr_idx] | {4'b0000, nibble};
      end
    end
    if (cmd.take_tick) begin
      scan_row   <= row_inc(lit_next);
      scan_latch <= latch_pending;
    end
    if (cmd.scan_rd) begin
      s1_latch <= (k == '0) && scan_latch;
      s1_last  <= stat.k_last;
      s1_zero  <= !row_valid[scan_row];
      s1_anode <= lit_row;
    end
    if (s1_valid && out_free) begin
      anode_row   <= lmrs_pkg::ANODE_W'(s1_anode);
      latch_pulse <= s1_latch;
      shift_byte  <= s1_zero ? '0 : ram_rd_data;
      last        <= s1_last;
    end
  end

endmodule

@@ rtl/led_matrix_line_loader_and_row_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// led_matrix_line_loader_and_row_scanner_unit
// Row scan controller for a multiplexed LED matrix with a serial line loader.
// ----------------------------------------------------------------------------
// The block keeps a ROWS x BYTES_PER_ROW frame store. Serial characters
// (command 0) run a line parser: '$' opens a line, a digit picks the row, then
// lower-case hex digits fill half a row; the last digit commits the row, low
// half zero and upper half the received bytes. The character that completes
// a line adds BYTES_PER_ROW frame store writes, one per cycle through the
// single write port, during which no item is accepted. A row tick (command 1)
// advances the lit row and streams BYTES_PER_ROW result transfers, one per
// frame store read, so a tick holds the input while its reads are issued;
// results leave through an output register at one per cycle while the sink
// is ready. Frame store reset is handled by one valid bit per row, so there
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module led_matrix_line_loader_and_row_scanner_unit #(
  parameter int ROWS          = lmrs_pkg::ROWS_DEFAULT,
  parameter int BYTES_PER_ROW = lmrs_pkg::BYTES_PER_ROW_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  lmrs_in_if.sink    item,
  lmrs_out_if.source result
);

  // command and status between sequencer and datapath
  lmrs_pkg::lmrs_cmd_t  cmd;
  lmrs_pkg::lmrs_stat_t stat;

  // sequencer: idle takes items; commit and unstalled scan go a byte a cycle
  lmrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_command (item.command),
    .in_ready   (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: parser, frame store, read pipeline and output register
  lmrs_datapath #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .rx_byte     (item.rx_byte),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .anode_row   (result.anode_row),
    .latch_pulse (result.latch_pulse),
    .shift_byte  (result.shift_byte),
    .last        (result.last)
  );

  // a commit write and a scan read never share the frame store port
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit_wr && cmd.scan_rd))
    else $error("commit write and scan read in the same cycle");

  // no sweep runs while the input side is open
  a_no_sweep_when_ready: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> (!cmd.commit_wr && !cmd.scan_rd))
    else $error("frame store sweep while accepting items");

  // a tick transfer always starts a scan, so the input closes next cycle
  a_tick_closes_input: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.command == lmrs_pkg::CMD_TICK)) |=> !item.ready)
    else $error("input still open after a tick transfer");

  // a latch pulse only ever rides on a transfer that is not the row's end
  a_latch_not_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.latch_pulse) |-> !result.last)
    else $error("latch pulse on the final byte of a row");

endmodule

@@ bench/led_matrix_line_loader_and_row_scanner_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_matrix_line_loader_and_row_scanner_unit_test
// Self-checking bench for the LED row scanner. Serial lines and row ticks are
// sent at a random pace. A local frame store model predicts every byte that a
// tick streams out, and each result transfer is checked field by field.
// ----------------------------------------------------------------------------
module led_matrix_line_loader_and_row_scanner_unit_test;

  localparam int ROWS          = lmrs_pkg::ROWS_DEFAULT;
  localparam int BYTES_PER_ROW = lmrs_pkg::BYTES_PER_ROW_DEFAULT;
  localparam int HALF_ROW      = BYTES_PER_ROW / 2;
  localparam int LINE_DIGITS   = 2 * HALF_ROW;
  localparam int BYTE_W        = lmrs_pkg::BYTE_W;
  localparam int ANODE_W       = lmrs_pkg::ANODE_W;

  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_PCT      = 27;
  localparam int ITEM_TARGET   = 470;
  // a commit writes BYTES_PER_ROW bytes with no result, so settle past it
  localparam int SETTLE_CYCLES = 3 * BYTES_PER_ROW;
  localparam int TIMEOUT_NS    = 1_000_000;

  // input commands
  localparam logic CMD_SERIAL = lmrs_pkg::CMD_SERIAL;
  localparam logic CMD_TICK   = lmrs_pkg::CMD_TICK;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = lmrs_pkg::CHAR_DOLLAR;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = lmrs_pkg::CHAR_ZERO;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = lmrs_pkg::CHAR_NINE;
  localparam logic [BYTE_W-1:0] CHAR_LOW_A  = lmrs_pkg::CHAR_LOW_A;
  localparam logic [BYTE_W-1:0] CHAR_LOW_F  = lmrs_pkg::CHAR_LOW_F;

  // upper-case hex is not accepted by the parser
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = "A";

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_ROW,
    PARSE_DATA
  } parse_phase_t;

  typedef struct {
    logic [ANODE_W-1:0] anode_row;
    logic               latch_pulse;
    logic [BYTE_W-1:0]  shift_byte;
    logic               last;
  } scan_byte_t;

  logic clk = 1'b0;
  logic rst;

  lmrs_in_if  serial_in ();
  lmrs_out_if scan_out ();

  led_matrix_line_loader_and_row_scanner_unit #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (serial_in),
    .result (scan_out)
  );

  always #1 clk = ~clk;

  // local copy of the frame store and the line parser
  logic [BYTE_W-1:0] frame [ROWS][BYTES_PER_ROW];
  logic [BYTE_W-1:0] line_bytes [HALF_ROW];
  parse_phase_t      phase;
  int                digits;
  int                target_row;
  int                lit_row;
  logic              latch_due;

  // bytes the scanner still owes, oldest first
  scan_byte_t scan_bytes_due [$];

  int   mismatches;
  int   loader_items;   // transfers that reach the parser or the scanner
  logic steady;         // no idling on either side while set

  // ---------------------------------------------------------------------------
  // prediction: apply one accepted transfer to the local model
  // ---------------------------------------------------------------------------
  task automatic advance_frame_model(input logic cmd, input logic [BYTE_W-1:0] ch);
    int         nib;
    int         slot;
    int         shown_row;
    scan_byte_t due;
    if (cmd == CMD_TICK) begin
      loader_items++;
      // advance the lit row, then stream the row after it
      lit_row   = (lit_row + 1) % ROWS;
      shown_row = (lit_row + 1) % ROWS;
      for (int k = 0; k < BYTES_PER_ROW; k++) begin
        due.anode_row   = ANODE_W'(lit_row);
        due.latch_pulse = (k == 0) ? latch_due : 1'b0;
        due.shift_byte  = frame[shown_row][k];
        due.last        = (k == BYTES_PER_ROW - 1);
        scan_bytes_due.push_back(due);
      end
      // every tick shifts a whole row, so a latch is owed from now on
      latch_due = 1'b1;
    end else begin
      // characters in idle other than the line opener are simply dropped
      if (ch == CHAR_DOLLAR || phase != PARSE_IDLE) loader_items++;
      if (ch == CHAR_DOLLAR) begin
        // opener, also a restart from anywhere inside a line
        digits = 0;
        phase  = PARSE_ROW;
      end else if (phase == PARSE_ROW) begin
        if (ch >= CHAR_ZERO && ch < CHAR_ZERO + ROWS) begin
          target_row = int'(ch - CHAR_ZERO);
          phase      = PARSE_DATA;
        end else begin
          // row digit out of range or any other character
          phase = PARSE_IDLE;
        end
      end else if (phase == PARSE_DATA) begin
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
          nib = int'(ch - CHAR_ZERO);
        end else if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_F) begin
          nib = int'(ch - CHAR_LOW_A) + 10;
        end else begin
          nib = -1;
        end
        if (nib < 0) begin
          // partial line is dropped
          phase = PARSE_IDLE;
        end else begin
          slot = (digits / 2) % HALF_ROW;
          if (digits % 2 == 1) begin
            line_bytes[slot] = line_bytes[slot] | BYTE_W'(nib);
          end else begin
            line_bytes[slot] = BYTE_W'(nib << 4);
          end
          digits++;
          if (digits >= LINE_DIGITS) begin
            // commit: low half cleared, upper half takes the line
            digits = 0;
            phase  = PARSE_IDLE;
            for (int i = 0; i < BYTES_PER_ROW - HALF_ROW; i++) begin
              frame[target_row][i] = '0;
            end
            for (int i = 0; i < HALF_ROW; i++) begin
              frame[target_row][BYTES_PER_ROW - HALF_ROW + i] = line_bytes[i];
            end
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? CHAR_ZERO + BYTE_W'(nib)
                         : CHAR_LOW_A + BYTE_W'(nib) - BYTE_W'(10);
  endfunction

  // one transfer on the input channel, with random idle cycles ahead of it
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] ch);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      serial_in.valid <= 1'b0;
      @(posedge clk);
    end
    serial_in.valid   <= 1'b1;
    serial_in.command <= cmd;
    serial_in.rx_byte <= ch;
    @(posedge clk);
    while (!serial_in.ready) @(posedge clk);
    advance_frame_model(cmd, ch);
  endtask

  task automatic send_char(input logic [BYTE_W-1:0] ch);
    send_item(CMD_SERIAL, ch);
  endtask

  // the character field is ignored on ticks, so it carries noise
  task automatic send_tick();
    send_item(CMD_TICK, BYTE_W'($urandom_range(255)));
  endtask

  task automatic send_line(input logic [BYTE_W-1:0] row_ch,
                           input logic [BYTE_W-1:0] line_data [HALF_ROW]);
    send_char(CHAR_DOLLAR);
    send_char(row_ch);
    foreach (line_data[i]) begin
      send_char(hex_char(line_data[i][7:4]));
      send_char(hex_char(line_data[i][3:0]));
    end
  endtask

  task automatic send_random_line();
    logic [BYTE_W-1:0] line_data [HALF_ROW];
    foreach (line_data[i]) line_data[i] = BYTE_W'($urandom_range(255));
    send_line(BYTE_W'(CHAR_ZERO + $urandom_range(ROWS - 1)), line_data);
  endtask

  // a line that stops short: bad row, junk, upper case or a restart
  task automatic send_broken_line();
    int cut;
    send_char(CHAR_DOLLAR);
    if ($urandom_range(3) == 0) begin
      send_char(BYTE_W'($urandom_range(255)));
    end else begin
      send_char(BYTE_W'(CHAR_ZERO + $urandom_range(ROWS - 1)));
      cut = $urandom_range(LINE_DIGITS - 1);
      repeat (cut) send_char(hex_char(4'($urandom_range(15))));
      case ($urandom_range(2))
        0: send_random_line();  // restart inside the data, digit count cleared
        1: send_char(BYTE_W'($urandom_range(255)));
        default: send_char(BYTE_W'(CHAR_UPPER_A + $urandom_range(5)));
      endcase
    end
  endtask

  // hold the input until the scanner has delivered everything owed
  task automatic wait_for_scan_drain();
    serial_in.valid <= 1'b0;
    while (scan_bytes_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("%0t ns: scan mismatch on %s, expected %0h, got %0h", $time, what, want, got);
  endtask

  // sink stalls at random unless a steady stretch is running
  always @(posedge clk) begin
    scan_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_scan
    scan_byte_t want;
    if (!rst && scan_out.valid && scan_out.ready) begin
      if (scan_bytes_due.size() == 0) begin
        report_mismatch("transfer with nothing owed, shift_byte", '0,
                        32'(scan_out.shift_byte));
      end else begin
        want = scan_bytes_due.pop_front();
        if (scan_out.anode_row !== want.anode_row) begin
          report_mismatch("anode_row", 32'(want.anode_row), 32'(scan_out.anode_row));
        end
        if (scan_out.latch_pulse !== want.latch_pulse) begin
          report_mismatch("latch_pulse", 32'(want.latch_pulse),
                          32'(scan_out.latch_pulse));
        end
        if (scan_out.shift_byte !== want.shift_byte) begin
          report_mismatch("shift_byte", 32'(want.shift_byte), 32'(scan_out.shift_byte));
        end
        if (scan_out.last !== want.last) begin
          report_mismatch("last", 32'(want.last), 32'(scan_out.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // first tick after reset owes no latch, the second one does
  task automatic test_first_ticks();
    send_tick();
    send_tick();
  endtask

  // restart inside a line, then a full line with extreme nibbles into row 5
  task automatic test_line_extremes();
    logic [BYTE_W-1:0] pattern [HALF_ROW];
    pattern = '{8'hff, 8'h00, 8'h01, 8'h23, 8'h45, 8'h67,
                8'h89, 8'hab, 8'hcd, 8'hef, 8'h5a, 8'hc3};
    send_char(CHAR_DOLLAR);
    send_char(BYTE_W'(CHAR_ZERO + 3));
    send_char(CHAR_LOW_A);
    send_char(CHAR_LOW_F);
    send_line(BYTE_W'(CHAR_ZERO + 5), pattern);
  endtask

  // rows out of range and upper-case hex leave the frame alone
  task automatic test_rejected_lines();
    send_char(CHAR_DOLLAR);
    send_char(BYTE_W'(CHAR_ZERO + ROWS));
    send_char(CHAR_DOLLAR);
    send_char(CHAR_NINE);
    send_char(CHAR_DOLLAR);
    send_char(BYTE_W'(CHAR_ZERO + 4));
    send_char(BYTE_W'(CHAR_LOW_A + 2));
    send_char(CHAR_UPPER_A);
  endtask

  // sweep the lit row past the loaded row and the aborted one
  task automatic test_row_sweep();
    repeat (ROWS) send_tick();
  endtask

  // the sender pauses until the scanner has caught up
  task automatic test_sender_pause();
    send_random_line();
    repeat (3) send_tick();
    wait_for_scan_drain();
    repeat (3) send_tick();
  endtask

  // back-to-back transfers on both sides
  task automatic test_steady_stream();
    steady = 1'b1;
    send_random_line();
    send_random_line();
    repeat (6) send_tick();
    send_random_line();
    repeat (2) send_tick();
    wait_for_scan_drain();
    steady = 1'b0;
  endtask

  // mostly well-formed lines and ticks, with broken lines and noise mixed in
  task automatic test_random_traffic();
    int pick;
    while (loader_items < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_random_line();
      end else if (pick < 80) begin
        send_tick();
      end else if (pick < 92) begin
        send_broken_line();
      end else begin
        send_char(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    serial_in.valid   <= 1'b0;
    serial_in.command <= CMD_SERIAL;
    serial_in.rx_byte <= '0;
    steady       = 1'b0;
    mismatches   = 0;
    loader_items = 0;
    // model at reset: frame cleared, parser idle, row 0 lit, no latch owed
    foreach (frame[r, k]) frame[r][k] = '0;
    foreach (line_bytes[i]) line_bytes[i] = '0;
    phase      = PARSE_IDLE;
    digits     = 0;
    target_row = 0;
    lit_row    = 0;
    latch_due  = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_first_ticks();
    test_line_extremes();
    test_rejected_lines();
    test_row_sweep();
    test_sender_pause();
    test_steady_stream();
    test_random_traffic();

    wait_for_scan_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && scan_bytes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lmrs_pkg.sv
rtl/lmrs_in_if.sv
rtl/lmrs_out_if.sv
rtl/lmrs_ram.sv
rtl/lmrs_ctrl.sv
rtl/lmrs_datapath.sv
rtl/led_matrix_line_loader_and_row_scanner_unit.sv
bench/led_matrix_line_loader_and_row_scanner_unit_test.sv
